// ===== rtl/bat_pkg.sv =====
// -----------------------------------------------------------------------------
// Breakpoint address table package
// Shared types and constants for the breakpoint address table and its checker.
// -----------------------------------------------------------------------------
package bat_pkg;

  // Field widths of the request and result transactions.
  localparam int unsigned KindW     = 3;
  localparam int unsigned ByteAddrW = 18;
  localparam int unsigned WordAddrW = 17;
  localparam int unsigned UsedW     = 4;

  // Packed stream widths; the data widths are padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 8;

  // Request type codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // The only breakpoint kind that is acted on.
  localparam logic [KindW-1:0] KindSoftware = 3'd0;

  // Status codes.
  localparam logic StatusDone        = 1'b0;
  localparam logic StatusUnsupported = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StShift,
    StDone
  } bat_state_e;

endpackage

// ===== rtl/breakpoint_address_table.sv =====
// An unsupported kind gives its result in the cycle after the request is accepted. A new
// insert or a miss searches all entries; a duplicate insert stops at its match, and a remove
// hit shifts later entries down. The search reads one entry per cycle and a remove shifts one
// per cycle. One request at a time: the next is taken the cycle after the result is consumed.
// Reset clears the count and the control state at once; list contents stay undefined until
// written, and only entries below the count are ever read, so no clearing pass is needed.
// -----------------------------------------------------------------------------
// Breakpoint address table
// Keeps a compact list of software breakpoint word addresses with insert and
// remove requests, using one shared compare/read port under a small sequencer.
// -----------------------------------------------------------------------------
module breakpoint_address_table
  import bat_pkg::*;
#(
  parameter int unsigned MAX_BREAKPOINTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [17:0] byte_address, rest zero
  input  logic [InUserW-1:0]  s_axis_tuser_i,   // [0] req_type, [3:1] point_kind
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [0] status, [1] table_full,
                                                // [2] address_matched,
                                                // [6:3] entries_in_use, [7] zero
);

  // Count must hold MAX_BREAKPOINTS itself; the index only needs the depth.
  localparam int unsigned CntW = $clog2(MAX_BREAKPOINTS + 1);
  localparam int unsigned IdxW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BREAKPOINTS);

  bat_state_e state_q, state_d;

  // Breakpoint list storage: one read port and one write port per cycle.
  logic [WordAddrW-1:0] list_q [MAX_BREAKPOINTS];

  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [WordAddrW-1:0] word_q, word_d;
  logic                 remove_q, remove_d;
  logic                 status_q, status_d;
  logic                 full_q, full_d;
  logic                 matched_q, matched_d;

  logic [CntW-1:0]      next_idx;
  logic [IdxW-1:0]      rd_idx;
  logic [WordAddrW-1:0] rd_data;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [WordAddrW-1:0] wr_data;
  logic                 in_fire;
  logic [CntW+UsedW-1:0] count_ext;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign next_idx = idx_q + CntW'(1);

  // The shared read port looks one entry ahead while the tail is moved down.
  assign rd_idx  = (state_q == StShift) ? next_idx[IdxW-1:0] : idx_q[IdxW-1:0];
  assign rd_data = list_q[rd_idx];

  // Sequencer: next state, datapath updates and list write strobes.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    word_d    = word_q;
    remove_d  = remove_q;
    status_d  = status_q;
    full_d    = full_q;
    matched_d = matched_q;
    wr_en     = 1'b0;
    wr_idx    = idx_q[IdxW-1:0];
    wr_data   = rd_data;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          word_d    = s_axis_tdata_i[ByteAddrW-1:1];
          remove_d  = (s_axis_tuser_i[0] == ReqRemove);
          full_d    = 1'b0;
          matched_d = 1'b0;
          idx_d     = '0;
          if (s_axis_tuser_i[KindW:1] != KindSoftware) begin
            status_d = StatusUnsupported;
            state_d  = StDone;
          end else begin
            status_d = StatusDone;
            state_d  = StSearch;
          end
        end
      end

      StSearch: begin
        // One stored entry is compared per cycle, from the oldest up.
        if (idx_q == count_q) begin
          // Address not listed.
          if (!remove_q) begin
            if (count_q >= MaxCnt) begin
              full_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_idx  = count_q[IdxW-1:0];
              wr_data = word_q;
              count_d = count_q + CntW'(1);
            end
          end
          state_d = StDone;
        end else if (rd_data == word_q) begin
          matched_d = 1'b1;
          // A duplicate insert leaves the list alone; a remove closes the gap.
          state_d   = remove_q ? StShift : StDone;
        end else begin
          idx_d = next_idx;
        end
      end

      StShift: begin
        // Move each later entry down by one, then drop the count.
        if (next_idx < count_q) begin
          wr_en   = 1'b1;
          wr_idx  = idx_q[IdxW-1:0];
          wr_data = rd_data;
          idx_d   = next_idx;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = StDone;
        end
      end

      StDone: begin
        if (m_axis_tready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    word_q    <= word_d;
    remove_q  <= remove_d;
    status_q  <= status_d;
    full_q    <= full_d;
    matched_q <= matched_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      list_q[wr_idx] <= wr_data;
    end
  end

  // The reported count is the stored count masked to four bits.
  assign count_ext = {{UsedW{1'b0}}, count_q};

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StDone);
  assign m_axis_tdata_o  = {1'b0, count_ext[UsedW-1:0], matched_q, full_q, status_q};

endmodule

// ===== rtl/bat_checker.sv =====
// -----------------------------------------------------------------------------
// Breakpoint address table checker
// Port-level assertions on the request and result streams, bound to the top.
// -----------------------------------------------------------------------------
module bat_checker
  import bat_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // One request at a time: the block never takes a request while a result waits.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request taken while a result is pending");

  // An accepted request blocks further requests on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready stayed high after a request transaction");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

  // An unsupported kind never reports full or matched, and full excludes matched.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($countones(m_axis_tdata_o[2:0]) <= 1 && !m_axis_tdata_o[7]))
    else $error("conflicting result flags");

  // A consumed result returns the block to accepting requests next cycle.
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |=> s_axis_tready_o)
    else $error("block did not return to idle");

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
